FILE: sv/bpa_pkg.sv
// shared constants, codes and controller/datapath interface types of the page allocator
package bpa_pkg;

    localparam int PAGE_BYTES = 4096;
    localparam int MAX_PAGES  = 4096;
    localparam int ADDR_BITS  = 48;

    localparam int PAGE_SHIFT  = $clog2(PAGE_BYTES);
    localparam int PN_W        = ADDR_BITS - PAGE_SHIFT;
    localparam int WORD_BITS   = 64;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int MAP_WORDS   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int PAGE_IDX_W  = WORD_IDX_W + BIT_W;
    localparam int CNT_W       = $clog2(MAX_PAGES + 1);
    localparam int CMP_W       = PAGE_IDX_W + 1;

    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 4;
    localparam int REG_IDX_LSB = 3;

    localparam logic REG_REGION_START = 1'b0;
    localparam logic REG_REGION_END   = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_ALLOCATED     = 3'd0,
        ST_NO_MEMORY     = 3'd1,
        ST_FREED         = 3'd2,
        ST_NULL          = 3'd3,
        ST_RANGE         = 3'd4,
        ST_NOT_ALLOCATED = 3'd5
    } status_t;

    typedef struct packed {
        logic    reb_base;
        logic    reb_total;
        logic    reb_free;
        logic    capture;
        logic    calc_diff;
        logic    rd_free;
        logic    scan_start;
        logic    scan_step;
        logic    scan_capture;
        logic    alloc_commit;
        logic    free_commit;
        logic    res_we;
        status_t res_code;
        logic    load_out;
    } bpa_cmd_t;

    typedef struct packed {
        logic op_free;
        logic no_free;
        logic addr_null;
        logic below_base;
        logic out_of_range;
        logic bit_set;
        logic scan_hit;
        logic scan_done;
        logic idx_bad;
    } bpa_stat_t;

endpackage

FILE: sv/bpa_ram.sv
// generic single-write, single-read ram with registered read data
module bpa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/bpa_regs.sv
// apb register block holding the region start and end
module bpa_regs
    import bpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ADDR_BITS-1:0]  region_start,
    output logic [ADDR_BITS-1:0]  region_end,
    output logic                  cfg_wr
);

    logic [ADDR_BITS-1:0] region_start_reg;
    logic [ADDR_BITS-1:0] region_end_reg;
    logic                 reg_idx;

    assign reg_idx = paddr[REG_IDX_LSB];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_start_reg <= '0;
            region_end_reg   <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_REGION_START: region_start_reg <= pwdata[ADDR_BITS-1:0];
                REG_REGION_END:   region_end_reg   <= pwdata[ADDR_BITS-1:0];
                default:          region_end_reg   <= region_end_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_REGION_START: prdata = {{(CFG_DATA_W-ADDR_BITS){1'b0}}, region_start_reg};
            REG_REGION_END:   prdata = {{(CFG_DATA_W-ADDR_BITS){1'b0}}, region_end_reg};
            default:          prdata = '0;
        endcase
    end

    assign region_start = region_start_reg;
    assign region_end   = region_end_reg;

endmodule

FILE: sv/bpa_ctrl.sv
// allocator controller: sequences rebuild, allocate scan, free check and result transfer
module bpa_ctrl
    import bpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr,
    input  logic      in_valid,
    output logic      in_ready,
    output logic      out_valid,
    input  logic      out_ready,
    input  bpa_stat_t stat,
    output bpa_cmd_t  cmd
);

    typedef enum logic [9:0] {
        S_IDLE       = 10'b00_0000_0001,
        S_REB_BASE   = 10'b00_0000_0010,
        S_REB_TOTAL  = 10'b00_0000_0100,
        S_REB_FREE   = 10'b00_0000_1000,
        S_DECODE     = 10'b00_0001_0000,
        S_SCAN       = 10'b00_0010_0000,
        S_ALLOC_WR   = 10'b00_0100_0000,
        S_FREE_RANGE = 10'b00_1000_0000,
        S_FREE_CHK   = 10'b01_0000_0000,
        S_FINISH     = 10'b10_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_REB_BASE:
            begin
                cmd.reb_base = 1'b1;
                state_next   = S_REB_TOTAL;
            end
            S_REB_TOTAL:
            begin
                cmd.reb_total = 1'b1;
                state_next    = S_REB_FREE;
            end
            S_REB_FREE:
            begin
                cmd.reb_free = 1'b1;
                state_next   = S_IDLE;
            end
            S_DECODE:
            begin
                if (stat.op_free)
                begin
                    priority if (stat.addr_null)
                    begin
                        cmd.res_we   = 1'b1;
                        cmd.res_code = ST_NULL;
                        state_next   = S_FINISH;
                    end
                    else if (stat.below_base)
                    begin
                        cmd.res_we   = 1'b1;
                        cmd.res_code = ST_RANGE;
                        state_next   = S_FINISH;
                    end
                    else
                    begin
                        cmd.calc_diff = 1'b1;
                        state_next    = S_FREE_RANGE;
                    end
                end
                else if (stat.no_free)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = ST_NO_MEMORY;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                priority if (stat.scan_hit)
                begin
                    cmd.scan_capture = 1'b1;
                    state_next       = S_ALLOC_WR;
                end
                else if (stat.scan_done)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = ST_NO_MEMORY;
                    state_next   = S_FINISH;
                end
            end
            S_ALLOC_WR:
            begin
                cmd.res_we = 1'b1;
                if (stat.idx_bad)
                begin
                    cmd.res_code = ST_NO_MEMORY;
                end
                else
                begin
                    cmd.alloc_commit = 1'b1;
                    cmd.res_code     = ST_ALLOCATED;
                end
                state_next = S_FINISH;
            end
            S_FREE_RANGE:
            begin
                if (stat.out_of_range)
                begin
                    cmd.res_we   = 1'b1;
                    cmd.res_code = ST_RANGE;
                    state_next   = S_FINISH;
                end
                else
                begin
                    // fetch the bitmap word holding the page
                    cmd.rd_free = 1'b1;
                    state_next  = S_FREE_CHK;
                end
            end
            S_FREE_CHK:
            begin
                cmd.res_we = 1'b1;
                if (stat.bit_set)
                begin
                    cmd.free_commit = 1'b1;
                    cmd.res_code    = ST_FREED;
                end
                else
                begin
                    cmd.res_code = ST_NOT_ALLOCATED;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        // a register write restarts the rebuild
        if (cfg_wr)
        begin
            state_next = S_REB_BASE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

FILE: sv/bpa_datapath.sv
// allocator datapath: region geometry, bitmap ram, scan, free check and result registers
module bpa_datapath
    import bpa_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  bpa_cmd_t             cmd,
    output bpa_stat_t            stat,
    input  logic [ADDR_BITS-1:0] region_start,
    input  logic [ADDR_BITS-1:0] region_end,
    input  logic                 opcode,
    input  logic [ADDR_BITS-1:0] address,
    output logic [2:0]           status,
    output logic [ADDR_BITS-1:0] page_address,
    output logic [CNT_W-1:0]     free_count,
    output logic [CNT_W-1:0]     total_count
);

    localparam int RES_W = ((CNT_W > PAGE_SHIFT) ? CNT_W : PAGE_SHIFT) + 2;

    // region geometry and counters
    logic [PN_W-1:0]   base_pn_reg;
    logic              wrapped_reg;
    logic [CNT_W-1:0]  page_total_reg;
    logic [CNT_W-1:0]  reserved_reg;
    logic [CNT_W-1:0]  free_pages_reg;
    logic [MAP_WORDS-1:0] row_valid_reg;

    // current item
    logic                 op_reg;
    logic [ADDR_BITS-1:0] addr_reg;
    logic [ADDR_BITS-1:0] diff_reg;

    // scan state
    logic [WORD_IDX_W:0]   scan_ptr_reg;
    logic                  chk_valid_reg;
    logic [WORD_IDX_W-1:0] raddr_q_reg;
    logic [PAGE_IDX_W-1:0] found_idx_reg;
    logic [WORD_BITS-1:0]  found_data_reg;

    // staged result and output registers
    status_t              res_status_reg;
    logic [ADDR_BITS-1:0] res_addr_reg;
    status_t              out_status_reg;
    logic [ADDR_BITS-1:0] out_addr_reg;
    logic [CNT_W-1:0]     out_free_reg;
    logic [CNT_W-1:0]     out_total_reg;

    // combinational
    logic                  start_low_nz;
    logic [PN_W-1:0]       start_pn;
    logic                  start_wrap;
    logic [PN_W-1:0]       limit_pn;
    logic [PN_W-1:0]       span_pn;
    logic [CNT_W-1:0]      total_calc;
    logic [RES_W-1:0]      total_ext;
    logic [RES_W-1:0]      map_bytes_a;
    logic [RES_W-1:0]      map_bytes_b;
    logic [RES_W-1:0]      rsv_pages;
    logic [CNT_W-1:0]      reserved_calc;
    logic [ADDR_BITS:0]    sub_full;
    logic [PAGE_IDX_W-1:0] free_idx;
    logic [WORD_IDX_W-1:0] free_word;
    logic [BIT_W-1:0]      free_bit;
    logic [CNT_W:0]        words_calc;
    logic [WORD_IDX_W-1:0] raddr;
    logic [WORD_BITS-1:0]  ram_rdata;
    logic [WORD_BITS-1:0]  default_word;
    logic [WORD_BITS-1:0]  eff_word;
    logic [CMP_W-1:0]      row_lo;
    logic [CMP_W-1:0]      rsv_ext;
    logic [CMP_W-1:0]      rsv_left;
    logic [BIT_W-1:0]      zero_pos;
    logic                  ram_we;
    logic [WORD_IDX_W-1:0] ram_waddr;
    logic [WORD_BITS-1:0]  ram_wdata;
    logic [ADDR_BITS-1:0]  alloc_addr;

    // start rounded up; the top page cannot be rounded up into
    assign start_low_nz = |region_start[PAGE_SHIFT-1:0];
    assign start_pn     = region_start[ADDR_BITS-1:PAGE_SHIFT];
    assign start_wrap   = start_low_nz && (&start_pn);
    assign limit_pn     = region_end[ADDR_BITS-1:PAGE_SHIFT];
    assign span_pn      = limit_pn - base_pn_reg;

    always_comb
    begin
        if (wrapped_reg || (limit_pn <= base_pn_reg))
        begin
            total_calc = '0;
        end
        else if (span_pn > PN_W'(MAX_PAGES))
        begin
            total_calc = CNT_W'(MAX_PAGES);
        end
        else
        begin
            total_calc = span_pn[CNT_W-1:0];
        end
    end

    // pages taken by a byte-packed, 8-byte aligned copy of the bitmap
    assign total_ext   = RES_W'(page_total_reg);
    assign map_bytes_a = (total_ext + RES_W'(7)) >> 3;
    assign map_bytes_b = (map_bytes_a + RES_W'(7)) & ~RES_W'(7);
    assign rsv_pages   = (map_bytes_b + RES_W'(PAGE_BYTES - 1)) >> PAGE_SHIFT;
    assign reserved_calc = (rsv_pages > total_ext) ? page_total_reg : rsv_pages[CNT_W-1:0];

    // free address decode
    assign sub_full  = {1'b0, addr_reg} - {1'b0, base_pn_reg, {PAGE_SHIFT{1'b0}}};
    assign free_idx  = diff_reg[PAGE_SHIFT +: PAGE_IDX_W];
    assign free_word = free_idx[PAGE_IDX_W-1:BIT_W];
    assign free_bit  = free_idx[BIT_W-1:0];

    assign words_calc = ({1'b0, page_total_reg} + (CNT_W+1)'(WORD_BITS - 1)) >> BIT_W;

    assign raddr = cmd.rd_free ? free_word : scan_ptr_reg[WORD_IDX_W-1:0];

    // a row not written since the rebuild reads as its reset pattern
    assign row_lo   = {1'b0, raddr_q_reg, {BIT_W{1'b0}}};
    assign rsv_ext  = CMP_W'(reserved_reg);
    assign rsv_left = rsv_ext - row_lo;

    always_comb
    begin
        if (rsv_ext >= row_lo + CMP_W'(WORD_BITS))
        begin
            default_word = '1;
        end
        else if (rsv_ext <= row_lo)
        begin
            default_word = '0;
        end
        else
        begin
            default_word = ~({WORD_BITS{1'b1}} << rsv_left[BIT_W-1:0]);
        end
    end

    assign eff_word = row_valid_reg[raddr_q_reg] ? ram_rdata : default_word;

    // lowest clear bit of the word under check
    always_comb
    begin
        zero_pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--)
        begin
            if (!eff_word[i])
            begin
                zero_pos = BIT_W'(i);
            end
        end
    end

    assign alloc_addr = {base_pn_reg + PN_W'(found_idx_reg), {PAGE_SHIFT{1'b0}}};

    assign ram_we    = cmd.alloc_commit || cmd.free_commit;
    assign ram_waddr = cmd.alloc_commit ? found_idx_reg[PAGE_IDX_W-1:BIT_W] : free_word;
    assign ram_wdata = cmd.alloc_commit ? found_data_reg
                                        : (eff_word & ~(WORD_BITS'(1) << free_bit));

    bpa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    // status toward the controller
    assign stat.op_free      = (op_reg == OP_FREE);
    assign stat.no_free      = (free_pages_reg == '0);
    assign stat.addr_null    = (addr_reg == '0);
    assign stat.below_base   = sub_full[ADDR_BITS];
    assign stat.out_of_range = diff_reg[ADDR_BITS-1:PAGE_SHIFT]
                               >= {{(PN_W-CNT_W){1'b0}}, page_total_reg};
    assign stat.bit_set      = eff_word[free_bit];
    assign stat.scan_hit     = chk_valid_reg && (eff_word != '1);
    assign stat.scan_done    = !chk_valid_reg
                               && ({{(CNT_W-WORD_IDX_W){1'b0}}, scan_ptr_reg} >= words_calc);
    assign stat.idx_bad      = CMP_W'(found_idx_reg) >= CMP_W'(page_total_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_pn_reg    <= '0;
            wrapped_reg    <= 1'b0;
            page_total_reg <= '0;
            reserved_reg   <= '0;
            free_pages_reg <= '0;
            row_valid_reg  <= '0;
            scan_ptr_reg   <= '0;
            chk_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.reb_base)
            begin
                base_pn_reg <= start_wrap ? start_pn : start_pn + PN_W'(start_low_nz);
                wrapped_reg <= start_wrap;
            end
            if (cmd.reb_total)
            begin
                page_total_reg <= total_calc;
            end
            if (cmd.reb_free)
            begin
                reserved_reg   <= reserved_calc;
                free_pages_reg <= page_total_reg - reserved_calc;
                row_valid_reg  <= '0;
            end
            if (cmd.scan_start)
            begin
                scan_ptr_reg  <= '0;
                chk_valid_reg <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                if ({{(CNT_W-WORD_IDX_W){1'b0}}, scan_ptr_reg} < words_calc)
                begin
                    scan_ptr_reg  <= scan_ptr_reg + 1'b1;
                    chk_valid_reg <= 1'b1;
                end
                else
                begin
                    chk_valid_reg <= 1'b0;
                end
            end
            if (cmd.alloc_commit)
            begin
                row_valid_reg[found_idx_reg[PAGE_IDX_W-1:BIT_W]] <= 1'b1;
                free_pages_reg <= free_pages_reg - 1'b1;
            end
            if (cmd.free_commit)
            begin
                row_valid_reg[free_word] <= 1'b1;
                free_pages_reg <= free_pages_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        raddr_q_reg <= raddr;
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            addr_reg <= address;
        end
        if (cmd.calc_diff)
        begin
            diff_reg <= sub_full[ADDR_BITS-1:0];
        end
        if (cmd.scan_capture)
        begin
            found_idx_reg  <= {raddr_q_reg, zero_pos};
            found_data_reg <= eff_word | (WORD_BITS'(1) << zero_pos);
        end
        if (cmd.res_we)
        begin
            res_status_reg <= cmd.res_code;
            res_addr_reg   <= cmd.alloc_commit ? alloc_addr : '0;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_addr_reg   <= res_addr_reg;
            out_free_reg   <= free_pages_reg;
            out_total_reg  <= page_total_reg;
        end
    end

    assign status       = out_status_reg;
    assign page_address = out_addr_reg;
    assign free_count   = out_free_reg;
    assign total_count  = out_total_reg;

endmodule

FILE: sv/bitmap_page_allocator_unit.sv
// top level of the first-fit bitmap page allocator
//
// Handles one request at a time. An allocate walks the page bitmap one 64-bit word per cycle
// through the single read port of the bitmap ram until it finds a word with a clear bit or
// passes the last map word; an allocate with no free pages skips the scan. A null or
// below-base free is answered at decode, an out-of-range one after the range check. A new
// request is taken as soon as the previous result sits in the output register. After a
// register write the region is rebuilt in S_REB_BASE, S_REB_TOTAL and S_REB_FREE, during
// which in_ready stays low; the bitmap needs no clearing pass, since a per-word valid
// flag makes unwritten words read as their reset pattern.
module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [ADDR_BITS-1:0]  address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [2:0]            status,
    output logic [ADDR_BITS-1:0]  page_address,
    output logic [CNT_W-1:0]      free_count,
    output logic [CNT_W-1:0]      total_count
);

    logic [ADDR_BITS-1:0] region_start;
    logic [ADDR_BITS-1:0] region_end;
    logic                 cfg_wr;
    bpa_cmd_t             cmd;
    bpa_stat_t            stat;

    bpa_regs u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .region_start (region_start),
        .region_end   (region_end),
        .cfg_wr       (cfg_wr)
    );

    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bpa_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .region_start (region_start),
        .region_end   (region_end),
        .opcode       (opcode),
        .address      (address),
        .status       (status),
        .page_address (page_address),
        .free_count   (free_count),
        .total_count  (total_count)
    );

endmodule

FILE: tb/tb.sv
// self-checking testbench for the bitmap page allocator: directed table, then random traffic
module tb
    import bpa_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ADDR_TOP = (64'd1 << ADDR_BITS) - 64'd1;
    localparam int SEGMENTS = 8;
    localparam int SEG_REQUESTS = 215;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        status_t              st;
        logic [ADDR_BITS-1:0] page;
        logic [CNT_W-1:0]     free_pages;
        logic [CNT_W-1:0]     total_pages;
    } alloc_result_t;

    typedef enum logic {
        ROW_REQ,
        ROW_REG
    } row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic          op;
        logic          sel;
        logic [63:0]   data;
        logic          typed;
        alloc_result_t want;
    } stim_row_t;

    localparam int DIR_ROWS = 35;
    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        // empty region straight out of reset
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b1, '{ST_NO_MEMORY, 48'h0, 13'd0, 13'd0}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h0, 1'b1, '{ST_NULL, 48'h0, 13'd0, 13'd0}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'hFFFF_FFFF_FFFF, 1'b1, '{ST_RANGE, 48'h0, 13'd0, 13'd0}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h1, 1'b1, '{ST_RANGE, 48'h0, 13'd0, 13'd0}},
        // 64 pages at 0x1000, page 0 holds the map
        '{ROW_REG, OP_ALLOC, REG_REGION_START, 64'h1000, 1'b0, '0},
        '{ROW_REG, OP_ALLOC, REG_REGION_END, 64'h41000, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b1, '{ST_ALLOCATED, 48'h2000, 13'd62, 13'd64}},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h2abc, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h2000, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h1000, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'hfff, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h41000, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h40fff, 1'b0, '0},
        // page zero managed, three pages
        '{ROW_REG, OP_ALLOC, REG_REGION_START, 64'h0, 1'b0, '0},
        '{ROW_REG, OP_ALLOC, REG_REGION_END, 64'h3000, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h0, 1'b1, '{ST_NULL, 48'h0, 13'd2, 13'd3}},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b1, '{ST_NO_MEMORY, 48'h0, 13'd0, 13'd3}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h2000, 1'b0, '0},
        // start rounds up past the top of the address space
        '{ROW_REG, OP_ALLOC, REG_REGION_START, 64'hFFFF_FFFF_F001, 1'b0, '0},
        '{ROW_REG, OP_ALLOC, REG_REGION_END, 64'hFFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b1, '{ST_NO_MEMORY, 48'h0, 13'd0, 13'd0}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'hFFFF_FFFF_F800, 1'b1, '{ST_RANGE, 48'h0, 13'd0, 13'd0}},
        // oversized region, clamped to the map size
        '{ROW_REG, OP_ALLOC, REG_REGION_START, 64'h1234, 1'b0, '0},
        '{ROW_REG, OP_ALLOC, REG_REGION_END, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h1002000, 1'b0, '0},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h1001000, 1'b0, '0},
        // inverted region
        '{ROW_REG, OP_ALLOC, REG_REGION_START, 64'h10000, 1'b0, '0},
        '{ROW_REG, OP_ALLOC, REG_REGION_END, 64'h8000, 1'b0, '0},
        '{ROW_REQ, OP_ALLOC, 1'b0, 64'h0, 1'b1, '{ST_NO_MEMORY, 48'h0, 13'd0, 13'd0}},
        '{ROW_REQ, OP_FREE, 1'b0, 64'h9000, 1'b1, '{ST_RANGE, 48'h0, 13'd0, 13'd0}}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic                  opcode = OP_ALLOC;
    logic [ADDR_BITS-1:0]  address = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic [2:0]            status;
    logic [ADDR_BITS-1:0]  page_address;
    logic [CNT_W-1:0]      free_count;
    logic [CNT_W-1:0]      total_count;

    // shadow copy of the allocator
    logic [ADDR_BITS-1:0]  shadow_start = '0;
    logic [ADDR_BITS-1:0]  shadow_end = '0;
    logic [ADDR_BITS-1:0]  shadow_base;
    logic [MAX_PAGES-1:0]  shadow_map;
    int unsigned           shadow_free;
    int unsigned           shadow_total;

    alloc_result_t         pending_outcomes[$];
    logic [ADDR_BITS-1:0]  live_pages[$];
    logic [ADDR_BITS-1:0]  last_freed = '0;

    int unsigned in_idle_pct = 0;
    int unsigned out_stall_pct = 0;
    int unsigned err_count = 0;
    int unsigned req_count = 0;
    int unsigned result_count = 0;
    int unsigned write_count = 0;
    int unsigned status_seen [6];

    bitmap_page_allocator_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .address      (address),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .page_address (page_address),
        .free_count   (free_count),
        .total_count  (total_count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic void check_field(input string name, input logic [ADDR_BITS-1:0] want,
                                        input logic [ADDR_BITS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_count++;
        end
    endfunction

    // region setup: round start up and end down, clamp, reserve the pages the map would fill
    function automatic void rebuild_region();
        logic [63:0] up;
        logic [63:0] lim;
        logic [63:0] pages;
        int unsigned map_bytes;
        int unsigned reserved;
        bit          wrapped;
        up = {16'h0, shadow_start} & ~64'(PAGE_BYTES - 1);
        wrapped = 1'b0;
        if (up != {16'h0, shadow_start})
        begin
            if (up > ADDR_TOP - 64'(PAGE_BYTES))
                wrapped = 1'b1;
            else
                up = up + 64'(PAGE_BYTES);
        end
        lim = {16'h0, shadow_end} & ~64'(PAGE_BYTES - 1);
        if (wrapped || lim <= up)
            pages = '0;
        else
            pages = (lim - up) / 64'(PAGE_BYTES);
        if (pages > 64'(MAX_PAGES))
            pages = 64'(MAX_PAGES);
        shadow_base = up[ADDR_BITS-1:0];
        shadow_total = 32'(pages);
        map_bytes = ((shadow_total + 32'd7) / 32'd8 + 32'd7) & ~32'd7;
        reserved = (map_bytes + 32'(PAGE_BYTES) - 32'd1) / 32'(PAGE_BYTES);
        if (reserved > shadow_total)
            reserved = shadow_total;
        shadow_map = '0;
        for (int unsigned i = 0; i < reserved; i++)
            shadow_map[i] = 1'b1;
        shadow_free = shadow_total - reserved;
        live_pages.delete();
        // the map pages count as used, so they are fair game for a free
        if (reserved != 0)
            live_pages.push_back(shadow_base);
    endfunction

    function automatic alloc_result_t allocator_outcome(input logic op,
                                                        input logic [ADDR_BITS-1:0] a);
        alloc_result_t r;
        int unsigned   first_clear;
        logic [63:0]   frame;
        r.st = ST_NO_MEMORY;
        r.page = '0;
        if (op == OP_ALLOC)
        begin
            first_clear = MAX_PAGES;
            for (int unsigned i = 0; i < MAX_PAGES; i++)
            begin
                if (!shadow_map[i])
                begin
                    first_clear = i;
                    break;
                end
            end
            if (shadow_free != 0 && first_clear < shadow_total)
            begin
                shadow_map[first_clear] = 1'b1;
                shadow_free--;
                r.st = ST_ALLOCATED;
                r.page = shadow_base + ADDR_BITS'(first_clear) * ADDR_BITS'(PAGE_BYTES);
            end
        end
        else if (a == '0)
            r.st = ST_NULL;
        else if (a < shadow_base)
            r.st = ST_RANGE;
        else
        begin
            frame = 64'(a - shadow_base) / 64'(PAGE_BYTES);
            if (frame >= 64'(shadow_total))
                r.st = ST_RANGE;
            else if (!shadow_map[frame])
                r.st = ST_NOT_ALLOCATED;
            else
            begin
                shadow_map[frame] = 1'b0;
                shadow_free++;
                r.st = ST_FREED;
            end
        end
        r.free_pages = CNT_W'(shadow_free);
        r.total_pages = CNT_W'(shadow_total);
        return r;
    endfunction

    task automatic send_request(input logic op, input logic [ADDR_BITS-1:0] a,
                                input logic typed, input alloc_result_t fixed);
        alloc_result_t predicted;
        @(negedge clk);
        while ($urandom_range(0, 99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        address <= a;
        do @(posedge clk); while (!in_ready);
        predicted = allocator_outcome(op, a);
        pending_outcomes.push_back(typed ? fixed : predicted);
        if (predicted.st == ST_ALLOCATED)
            live_pages.push_back(predicted.page);
        req_count++;
    endtask

    task automatic drain_outcomes();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_region(input logic sel, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CFG_ADDR_W'(sel) << REG_IDX_LSB;
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (sel == REG_REGION_START)
            shadow_start = value[ADDR_BITS-1:0];
        else
            shadow_end = value[ADDR_BITS-1:0];
        rebuild_region();
        write_count++;
        // read it straight back
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        check_field("register readback", value[ADDR_BITS-1:0], prdata[ADDR_BITS-1:0]);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(negedge clk)
        out_ready <= ($urandom_range(0, 99) >= out_stall_pct);

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $display("%0t: result with nothing expected, expected none, got status %0d page %0h",
                         $time, status, page_address);
                err_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                result_count++;
                status_seen[want.st]++;
                check_field("status", ADDR_BITS'(want.st), ADDR_BITS'(status));
                check_field("page_address", want.page, page_address);
                check_field("free_count", ADDR_BITS'(want.free_pages), ADDR_BITS'(free_count));
                check_field("total_count", ADDR_BITS'(want.total_pages),
                            ADDR_BITS'(total_count));
            end
        end
    end

    initial
    begin
        int                   kind;
        int                   pick;
        int                   slot;
        logic                 op;
        logic [ADDR_BITS-1:0] a;
        logic [63:0]          lo;
        logic [63:0]          hi;
        rebuild_region();
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            if (DIR_TABLE[i].kind == ROW_REG)
            begin
                drain_outcomes();
                write_region(DIR_TABLE[i].sel, DIR_TABLE[i].data);
            end
            else
                send_request(DIR_TABLE[i].op, DIR_TABLE[i].data[ADDR_BITS-1:0],
                             DIR_TABLE[i].typed, DIR_TABLE[i].want);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            drain_outcomes();
            case (seg % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 51; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 51; end
                default: begin in_idle_pct = 23; out_stall_pct = 23; end
            endcase

            // region shapes: up to 80 pages, up to six pages, up to the top, around the map size
            kind = (seg + seg / 4) % 4;
            lo = {$urandom(), $urandom()};
            case (kind)
                0:
                begin
                    lo[47:46] = 2'b00;
                    hi = lo + 64'($urandom_range(1, 80)) * 64'(PAGE_BYTES)
                         + 64'($urandom_range(0, PAGE_BYTES - 1));
                end
                1:
                begin
                    lo[47:46] = 2'b00;
                    hi = lo + 64'($urandom_range(1, 6)) * 64'(PAGE_BYTES);
                end
                2:
                    hi = '1;
                default:
                begin
                    lo[47:40] = 8'h00;
                    hi = lo + 64'($urandom_range(4000, 4300)) * 64'(PAGE_BYTES);
                end
            endcase
            if ($urandom_range(0, 1) == 1)
            begin
                write_region(REG_REGION_START, lo);
                write_region(REG_REGION_END, hi);
            end
            else
            begin
                write_region(REG_REGION_END, hi);
                write_region(REG_REGION_START, lo);
            end

            for (int n = 0; n < SEG_REQUESTS; n++)
            begin
                if ((seg == 1 && n == 100) || $urandom_range(0, 199) == 0)
                    drain_outcomes();
                pick = $urandom_range(0, 99);
                op = OP_FREE;
                a = ADDR_BITS'({$urandom(), $urandom()});
                if (pick < 48)
                    op = OP_ALLOC;
                else if (pick < 80 && live_pages.size() != 0)
                begin
                    slot = $urandom_range(0, live_pages.size() - 1);
                    a = live_pages[slot];
                    if ($urandom_range(0, 1) == 1)
                        a[PAGE_SHIFT-1:0] = PAGE_SHIFT'($urandom());
                    live_pages.delete(slot);
                    last_freed = a;
                end
                else if (pick < 86)
                    a = last_freed;
                else if (pick < 93)
                    a = shadow_base
                        + ADDR_BITS'($urandom_range(0, shadow_total + 2)) * ADDR_BITS'(PAGE_BYTES)
                        + ADDR_BITS'($urandom_range(0, PAGE_BYTES - 1));
                else if (pick < 96)
                    a = '0;
                send_request(op, a, 1'b0, '0);
            end
        end

        drain_outcomes();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_outcomes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_outcomes.size());
            err_count++;
        end
        $display("covered %0d requests, %0d results checked, %0d region writes",
                 req_count, result_count, write_count);
        $display("outcomes: alloc %0d, out of memory %0d, freed %0d, null %0d, range %0d, %s %0d",
                 status_seen[ST_ALLOCATED], status_seen[ST_NO_MEMORY], status_seen[ST_FREED],
                 status_seen[ST_NULL], status_seen[ST_RANGE], "unowned",
                 status_seen[ST_NOT_ALLOCATED]);
        if (err_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("timeout waiting for the allocator");
        $display("Regression FAIL");
        $finish;
    end

endmodule

FILE: bitmap_page_allocator_unit.f
sv/bpa_pkg.sv
sv/bpa_ram.sv
sv/bpa_regs.sv
sv/bpa_ctrl.sv
sv/bpa_datapath.sv
sv/bitmap_page_allocator_unit.sv
tb/tb.sv
